>>> rtl/b64lw_pkg.sv
// shared types, constants and symbol lookup for the base64 line-wrapping encoder
package b64lw_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] GROUPS_PER_LINE_RESET = 8'd19;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'd61;

  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_PAD1 = 2'd1;
  localparam logic [1:0] KIND_PAD2 = 2'd2;

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  kind;
    logic        crlf;
    logic        last;
  } group_cmd_t;

  localparam int unsigned CMD_WIDTH = $bits(group_cmd_t);

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'd0;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

>>> rtl/b64lw_front.sv
// front end: gathers bytes into groups, tracks the line, issues group commands
module b64lw_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [7:0]              cfg_data,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    cmd_push,
  output b64lw_pkg::group_cmd_t   cmd
);

  logic [7:0]  groups_per_line;
  logic [1:0]  group_phase;
  logic [15:0] held_bytes;
  logic [7:0]  line_group_count;
  logic [7:0]  count_inc;
  logic [1:0]  phase;

  assign phase = (group_phase == 2'd3) ? 2'd0 : group_phase;
  assign count_inc = line_group_count + 8'd1;

  always_comb begin
    cmd_push   = 1'b0;
    cmd.bytes  = 24'd0;
    cmd.kind   = b64lw_pkg::KIND_FULL;
    cmd.crlf   = 1'b0;
    cmd.last   = last_byte;
    if (phase == 2'd2) begin
      cmd_push  = accept;
      cmd.bytes = {held_bytes, data_byte};
      cmd.crlf  = (count_inc == groups_per_line);
    end else if (last_byte) begin
      cmd_push = accept;
      if (phase == 2'd0) begin
        cmd.bytes = {data_byte, 16'd0};
        cmd.kind  = b64lw_pkg::KIND_PAD2;
      end else begin
        cmd.bytes = {held_bytes[15:8], data_byte, 8'd0};
        cmd.kind  = b64lw_pkg::KIND_PAD1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line  <= b64lw_pkg::GROUPS_PER_LINE_RESET;
      group_phase      <= 2'd0;
      held_bytes       <= 16'd0;
      line_group_count <= 8'd0;
    end else begin
      if (cfg_valid) begin
        groups_per_line <= cfg_data;
      end
      if (accept) begin
        if (last_byte) begin
          group_phase      <= 2'd0;
          held_bytes       <= 16'd0;
          line_group_count <= 8'd0;
        end else if (phase == 2'd2) begin
          group_phase      <= 2'd0;
          held_bytes       <= 16'd0;
          line_group_count <= (count_inc == groups_per_line) ? 8'd0 : count_inc;
        end else if (phase == 2'd0) begin
          group_phase <= 2'd1;
          held_bytes  <= {data_byte, 8'd0};
        end else begin
          group_phase <= 2'd2;
          held_bytes  <= {held_bytes[15:8], data_byte};
        end
      end
    end
  end

endmodule

>>> rtl/b64lw_queue.sv
// short register queue of group commands between front and back
module b64lw_queue #(
  parameter int unsigned DEPTH = b64lw_pkg::QUEUE_DEPTH,
  parameter int unsigned WIDTH = b64lw_pkg::CMD_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/b64lw_back.sv
// back end: expands one group command into characters, one per cycle while pop is high
module b64lw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  b64lw_pkg::group_cmd_t q_cmd,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_char,
  output logic                  last_char
);

  b64lw_pkg::group_cmd_t cur;
  logic       cur_valid;
  logic [2:0] char_idx;
  logic [2:0] last_idx;
  logic       at_end;
  logic       done;
  logic [5:0] s0;
  logic [5:0] s1;
  logic [5:0] s2;
  logic [5:0] s3;

  assign s0 = cur.bytes[23:18];
  assign s1 = {cur.bytes[17:16], cur.bytes[15:12]};
  assign s2 = {cur.bytes[11:8], cur.bytes[7:6]};
  assign s3 = cur.bytes[5:0];

  assign last_idx = (cur.kind == b64lw_pkg::KIND_FULL && cur.crlf) ? 3'd5 : 3'd3;
  assign at_end   = (char_idx == last_idx);
  assign done     = cur_valid && pop && at_end;
  assign q_pop    = q_valid && (!cur_valid || done);

  assign empty     = !cur_valid;
  assign last_char = cur.last && at_end;

  always_comb begin
    case (char_idx)
      3'd0: out_char = b64lw_pkg::sym_char(s0);
      3'd1: out_char = b64lw_pkg::sym_char(s1);
      3'd2: out_char = (cur.kind == b64lw_pkg::KIND_PAD2) ? b64lw_pkg::CHAR_PAD
                                                         : b64lw_pkg::sym_char(s2);
      3'd3: out_char = (cur.kind == b64lw_pkg::KIND_FULL) ? b64lw_pkg::sym_char(s3)
                                                         : b64lw_pkg::CHAR_PAD;
      3'd4: out_char = b64lw_pkg::CHAR_CR;
      default: out_char = b64lw_pkg::CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      char_idx  <= 3'd0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        char_idx  <= 3'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
        char_idx  <= 3'd0;
      end else if (cur_valid && pop) begin
        char_idx <= char_idx + 3'd1;
      end
    end
  end

endmodule

>>> rtl/base64_encoder_line_wrap.sv
// top level of the base64 encoder with CR LF line wrapping
//
// input queue side: raise push with data_byte and last_byte; a byte is taken
// at a clock edge where push is high and full is low. every third byte, or
// the byte marked last_byte, forms one group request for the back end.
// output queue side: while empty is low, out_char holds the oldest character
// and last_char marks the final character of a message; pop takes it.
// configuration: cfg_data sets groups_per_line (0 acts as 256), written when
// cfg_valid is high; cfg_ready is always high. write only while idle.
// flow: a group's first character shows after it passes the group queue
// into the back end's current-group register. the back end gives one
// character per cycle while pop is high, four per group (six with a line
// break); the front end takes a byte each cycle until the queue fills.
// when the receiver stalls, characters hold and the group queue absorbs up
// to QUEUE_DEPTH groups before full rises.
// reset: synchronous rst clears phase, line count and queues, and restores
// groups_per_line to 19 (76 characters per line).
module base64_encoder_line_wrap #(
  parameter int unsigned QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic                  accept;
  logic                  cmd_push;
  b64lw_pkg::group_cmd_t cmd;
  logic                  q_valid;
  logic                  q_pop;
  logic [b64lw_pkg::CMD_WIDTH-1:0] q_data;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  b64lw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (b64lw_pkg::CMD_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (b64lw_pkg::group_cmd_t'(q_data)),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule
